@@ hdl/nlqr_pkg.sv @@
// nlqr_pkg: shared types, constants and helper functions of the neighbor link quality ranker
// depends on nothing; used by every module of the block
`default_nettype none

package nlqr_pkg;

   // operation codes carried in cmd
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_DUMP    = 1'b1;

   // ranking keys
   localparam logic KEY_RSSI  = 1'b0;
   localparam logic KEY_RATIO = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_OWN_NODE_ID = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SORT_KEY    = 2'd1;

   localparam int RATIO_W = 15;
   localparam int NUM_W   = 23;   // count * 100 * 256 fits in 23 bits

   localparam logic [RATIO_W-1:0] RATIO_FULL = 15'd25600;
   localparam logic signed [7:0]  RSSI_FLOOR = -8'sd128;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        sender_id;
      logic [7:0]        seq_number;
      logic signed [7:0] packet_rssi;
   } item_type;

   typedef struct packed {
      logic [7:0]         id;
      logic signed [7:0]  rssi;
      logic [RATIO_W-1:0] ratio;
      logic [7:0]         count;
   } entry_type;

   typedef struct packed {
      logic [7:0] own_node_id;
      logic       sort_key;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] dividend;
      logic [7:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         entry_id;
      logic signed [7:0]  entry_rssi;
      logic [RATIO_W-1:0] entry_ratio;
      logic [3:0]         entry_rank;
      logic               last;
   } rsp_type;

   // larger value ranks higher; rssi gets its sign bit flipped
   function automatic logic [RATIO_W-1:0] rank_key(entry_type e, logic key);
      logic [RATIO_W-1:0] k;
      if (key == KEY_RATIO) begin
         k = e.ratio;
      end else begin
         k = {7'd0, ~e.rssi[7], e.rssi[6:0]};
      end
      return k;
   endfunction

   // count * 100 * 256 by shifts and adds
   function automatic logic [NUM_W-1:0] scale_count(logic [7:0] c);
      logic [14:0] p;
      p = {1'b0, c, 6'd0} + {2'b0, c, 5'd0} + {5'b0, c, 2'd0};
      return {p, 8'd0};
   endfunction

endpackage

`default_nettype wire

@@ hdl/nlqr_front.sv @@
// nlqr_front: accepts command items and holds them in a two-entry queue for the engine
// depends on nlqr_pkg
`default_nettype none

module nlqr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire nlqr_pkg::item_type item_in,
   output logic                    busy,
   output logic                    head_valid,
   output nlqr_pkg::item_type      head,
   input  wire logic               pop
);

   localparam int QD = 2;

   nlqr_pkg::item_type q_ff [QD];
   nlqr_pkg::item_type q_in [QD];
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;

   assign busy       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[0];
   assign push       = start & ~busy;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop && head_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end
      // after a pop the free slot sits right behind the remaining items
      if (push) begin
         q_in[cnt_in[0]] = item_in;
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule

`default_nettype wire

@@ hdl/nlqr_div.sv @@
// nlqr_div: restoring divider, one quotient bit per cycle, for the reception ratio
// depends on nlqr_pkg
`default_nettype none

module nlqr_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nlqr_pkg::div_req_type req,
   output nlqr_pkg::div_rsp_type      rsp
);

   localparam int NW     = nlqr_pkg::NUM_W;
   localparam int STEP_W = $clog2(NW);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [NW-1:0]     num_ff, num_in;
   logic [7:0]        rem_ff, rem_in, dvs_ff;
   logic [8:0]        shifted, diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      rem_in  = ge ? diff[7:0] : shifted[7:0];
      num_in  = {num_ff[NW-2:0], ge};
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff[nlqr_pkg::RATIO_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.valid && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (req.valid && !busy_ff) begin
         num_ff <= req.dividend;
         rem_ff <= 8'd0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/nlqr_engine.sv @@
// nlqr_engine: neighbor table, lookup and update, odd-even ranking passes and dump sequencer
// depends on nlqr_pkg; drives nlqr_div through its request and response structs
`default_nettype none

module nlqr_engine #(
   parameter int TABLE_ENTRIES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nlqr_pkg::cfg_type     cfg,
   input  wire logic                  head_valid,
   input  wire nlqr_pkg::item_type    head,
   output logic                       pop,
   output nlqr_pkg::div_req_type      div_req,
   input  wire nlqr_pkg::div_rsp_type div_rsp,
   output nlqr_pkg::rsp_type          rsp
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SORT = 3'd3;
   localparam logic [2:0] S_DUMP = 3'd4;

   logic [2:0]              state_ff, state_in;
   nlqr_pkg::entry_type     tbl_ff [TABLE_ENTRIES];
   nlqr_pkg::entry_type     tbl_in [TABLE_ENTRIES];
   nlqr_pkg::entry_type     sorted [TABLE_ENTRIES];
   nlqr_pkg::item_type      item_ff, item_in;
   logic [IW-1:0]           hit_ff, hit_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [TABLE_ENTRIES-1:0] rem_ff, rem_in;
   nlqr_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    found;
   logic [IW-1:0]           hit_idx;
   logic [7:0]              new_count;
   logic [TABLE_ENTRIES-1:0] mask, sel;

   // first matching id wins
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (tbl_ff[k].id == item_ff.sender_id) begin
            found   = 1'b1;
            hit_idx = IW'(k);
         end
      end
      new_count = tbl_ff[hit_idx].count + 8'd1;
   end

   always_comb begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         mask[k] = (tbl_ff[k].id != cfg.own_node_id);
      end
   end

   // one odd-even transposition pass; swapping only on strict less keeps ties in order
   always_comb begin
      sorted = tbl_ff;
      for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
         if (1'(k % 2) == idx_ff[0]) begin
            if (nlqr_pkg::rank_key(tbl_ff[k], cfg.sort_key) <
                nlqr_pkg::rank_key(tbl_ff[k+1], cfg.sort_key)) begin
               sorted[k]   = tbl_ff[k+1];
               sorted[k+1] = tbl_ff[k];
            end
         end
      end
   end

   assign sel = TABLE_ENTRIES'(1) << idx_ff;

   always_comb begin
      state_in         = state_ff;
      tbl_in           = tbl_ff;
      item_in          = item_ff;
      hit_in           = hit_ff;
      idx_in           = idx_ff;
      rem_in           = rem_ff;
      rsp_in           = rsp_ff;
      rsp_in.valid     = 1'b0;
      pop              = 1'b0;
      div_req.valid    = 1'b0;
      div_req.dividend = nlqr_pkg::scale_count(new_count);
      div_req.divisor  = item_ff.seq_number;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               item_in  = head;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            idx_in = '0;
            if (item_ff.cmd == nlqr_pkg::OP_DUMP) begin
               rem_in   = mask;
               state_in = S_DUMP;
            end else if (!found) begin
               state_in = S_IDLE;
            end else begin
               hit_in                 = hit_idx;
               tbl_in[hit_idx].count = new_count;
               tbl_in[hit_idx].rssi  = item_ff.packet_rssi;
               if (item_ff.seq_number == 8'd0) begin
                  tbl_in[hit_idx].ratio = '0;
                  state_in               = S_SORT;
               end else if (new_count >= item_ff.seq_number) begin
                  // ratio would reach or pass 100 percent
                  tbl_in[hit_idx].ratio = nlqr_pkg::RATIO_FULL;
                  state_in               = S_SORT;
               end else begin
                  div_req.valid = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               tbl_in[hit_ff].ratio = div_rsp.quotient;
               state_in             = S_SORT;
            end
         end
         S_SORT: begin
            tbl_in = sorted;
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_DUMP: begin
            if (rem_ff[idx_ff]) begin
               rsp_in.valid       = 1'b1;
               rsp_in.entry_id    = tbl_ff[idx_ff].id;
               rsp_in.entry_rssi  = tbl_ff[idx_ff].rssi;
               rsp_in.entry_ratio = tbl_ff[idx_ff].ratio;
               rsp_in.entry_rank  = 4'(idx_ff);
               rsp_in.last        = ((rem_ff & ~sel) == '0);
            end
            rem_in = rem_ff & ~sel;
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_ff.valid <= 1'b0;
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            tbl_ff[k].id    <= 8'(k + 1);
            tbl_ff[k].rssi  <= nlqr_pkg::RSSI_FLOOR;
            tbl_ff[k].ratio <= '0;
            tbl_ff[k].count <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
         tbl_ff       <= tbl_in;
      end
      item_ff            <= item_in;
      hit_ff             <= hit_in;
      idx_ff             <= idx_in;
      rem_ff             <= rem_in;
      rsp_ff.entry_id    <= rsp_in.entry_id;
      rsp_ff.entry_rssi  <= rsp_in.entry_rssi;
      rsp_ff.entry_ratio <= rsp_in.entry_ratio;
      rsp_ff.entry_rank  <= rsp_in.entry_rank;
      rsp_ff.last        <= rsp_in.last;
   end

endmodule

`default_nettype wire

@@ hdl/neighbor_link_quality_ranker.sv @@
// neighbor_link_quality_ranker: top level, register port, front queue, engine and divider
// depends on nlqr_pkg, nlqr_front, nlqr_div, nlqr_engine
//
//   channel   ports                                   handshake
//   request   req_cmd/sender_id/seq_number/rssi       accepted when start && !busy
//   response  rsp_entry_id/rssi/ratio/rank, rsp_last  rsp_valid strobe per item
//   config    csr_index, csr_wdata                    written when csr_valid && csr_ready
//
// a receive for an unknown sender ends without ranking; a known sender's entry is updated,
// passes through the 23-step serial divider when a division is needed, and is then ranked
// by one odd-even ranking pass per table entry. a dump visits every table entry in turn.
// up to two items wait in the front queue; busy rises when it is full.
// synchronous reset restores the table and the control registers.
// responses cannot be held off: a dump streams one entry per cycle, skipping the own node's entry.
`default_nettype none

module neighbor_link_quality_ranker #(
   parameter int TABLE_ENTRIES = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_cmd,
   input  wire logic [7:0]                       req_sender_id,
   input  wire logic [7:0]                       req_seq_number,
   input  wire logic signed [7:0]                req_packet_rssi,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_entry_id,
   output logic signed [7:0]                     rsp_entry_rssi,
   output logic [nlqr_pkg::RATIO_W-1:0]          rsp_entry_ratio,
   output logic [3:0]                            rsp_entry_rank,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [nlqr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_wdata
);

   logic [7:0]            own_id_ff;
   logic                  sort_key_ff;
   nlqr_pkg::cfg_type     cfg;
   nlqr_pkg::item_type    item_in, head;
   logic                  head_valid, pop;
   nlqr_pkg::div_req_type div_req;
   nlqr_pkg::div_rsp_type div_rsp;
   nlqr_pkg::rsp_type     rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff   <= 8'd0;
         sort_key_ff <= nlqr_pkg::KEY_RATIO;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == nlqr_pkg::REG_OWN_NODE_ID) begin
            own_id_ff <= csr_wdata;
         end else if (csr_index == nlqr_pkg::REG_SORT_KEY) begin
            sort_key_ff <= csr_wdata[0];
         end
      end
   end

   assign cfg.own_node_id = own_id_ff;
   assign cfg.sort_key    = sort_key_ff;

   assign item_in.cmd         = req_cmd;
   assign item_in.sender_id   = req_sender_id;
   assign item_in.seq_number  = req_seq_number;
   assign item_in.packet_rssi = req_packet_rssi;

   nlqr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .item_in    (item_in),
      .busy       (busy),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   nlqr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   nlqr_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp        (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_entry_id    = rsp.entry_id;
   assign rsp_entry_rssi  = rsp.entry_rssi;
   assign rsp_entry_ratio = rsp.entry_ratio;
   assign rsp_entry_rank  = rsp.entry_rank;
   assign rsp_last        = rsp.last;

`ifndef ASSERT_OFF
   a_last_ends_dump : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("response right after the last item of a dump");

   a_ratio_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_ratio <= nlqr_pkg::RATIO_FULL)
      else $error("dumped ratio above full scale");

   a_own_skipped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_id != $past(own_id_ff))
      else $error("own node entry was dumped");
`endif

endmodule

`default_nettype wire
